// ----- hw/rtl/fpbc_pkg.sv -----
package fpbc_pkg;

    // Directory geometry
    localparam int ENTRIES = 25;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PAGE_W  = 14;
    localparam int SLOT_W  = 5;
    localparam int OP_W    = 2;
    localparam int ACT_W   = 3;

    // Request operations
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_HIT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WB      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MARKED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ABSENT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NOFLUSH = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [PAGE_W-1:0] page;
    } t_in_item;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] target_page;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_LOAD
    } t_state;

    // Which result the datapath builds (and which state update goes with it)
    typedef enum logic [2:0] {
        EM_NONE,
        EM_HIT,
        EM_EVICT,
        EM_LOAD,
        EM_MARK,
        EM_ABSENT,
        EM_FLUSH,
        EM_EMPTY
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  scan;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            victim_valid;
        logic            victim_dirty;
        logic            flush_found;
        logic            out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/fpbc_ctrl.sv -----
module fpbc_ctrl
    import fpbc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.scan    = 1'b0;
        o_cmd.emit    = EM_NONE;
        o_in_stall    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_READ: begin
                        if (i_sts.out_free) begin
                            if (i_sts.hit) begin
                                o_cmd.emit = EM_HIT;
                                n_state    = S_IDLE;
                            end else if (i_sts.victim_valid && i_sts.victim_dirty) begin
                                o_cmd.emit = EM_EVICT;
                                n_state    = S_LOAD;
                            end else begin
                                o_cmd.emit = EM_LOAD;
                                n_state    = S_IDLE;
                            end
                        end
                    end
                    OP_MARK: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = i_sts.hit ? EM_MARK : EM_ABSENT;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_FLUSH: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = i_sts.flush_found ? EM_FLUSH : EM_EMPTY;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        // unused code: dropped without a result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EM_LOAD;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/fpbc_dp.sv -----
module fpbc_dp
    import fpbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Directory
    logic [PAGE_W-1:0]  r_page [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_dirty;
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;

    // Request and scan results
    logic [OP_W-1:0]    r_op;
    logic [PAGE_W-1:0]  r_req_page;
    logic [ENTRIES-1:0] r_hit_vec;
    logic [ENTRIES-1:0] r_cand_vec;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic [IDX_W-1:0]   hit_idx;
    logic               hit_found;
    logic [IDX_W-1:0]   victim;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   fl_idx_hi;
    logic               fl_found_hi;
    logic [IDX_W-1:0]   fl_idx_all;
    logic               fl_found_all;
    logic [IDX_W-1:0]   fl_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [PAGE_W-1:0]  rd_page;
    logic               out_free;

    assign victim    = (r_tail == IDX_W'(ENTRIES - 1)) ? '0 : r_tail + 1'b1;
    assign head_next = (r_head == IDX_W'(ENTRIES - 1)) ? '0 : r_head + 1'b1;

    // Lowest matching slot
    always_comb begin
        hit_idx   = '0;
        hit_found = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                hit_idx   = IDX_W'(i);
                hit_found = 1'b1;
            end
        end
    end

    // First dirty slot from head onward, else from slot zero (ring wrap)
    always_comb begin
        fl_idx_hi    = '0;
        fl_found_hi  = 1'b0;
        fl_idx_all   = '0;
        fl_found_all = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_cand_vec[i]) begin
                fl_idx_all   = IDX_W'(i);
                fl_found_all = 1'b1;
                if (IDX_W'(i) >= r_head) begin
                    fl_idx_hi   = IDX_W'(i);
                    fl_found_hi = 1'b1;
                end
            end
        end
    end

    assign fl_idx  = fl_found_hi ? fl_idx_hi : fl_idx_all;
    assign rd_idx  = (i_cmd.emit == EM_FLUSH) ? fl_idx : victim;
    assign rd_page = r_page[rd_idx];

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.op           = r_op;
    assign o_sts.hit          = hit_found;
    assign o_sts.victim_valid = r_valid[victim];
    assign o_sts.victim_dirty = r_dirty[victim];
    assign o_sts.flush_found  = fl_found_all;
    assign o_sts.out_free     = out_free;

    always_comb begin
        n_out_item.action      = ACT_NOFLUSH;
        n_out_item.target_page = '0;
        n_out_item.slot        = '0;
        n_out_item.last        = 1'b1;
        case (i_cmd.emit)
            EM_HIT: begin
                n_out_item.action      = ACT_HIT;
                n_out_item.target_page = r_req_page;
                n_out_item.slot        = SLOT_W'(hit_idx);
            end
            EM_EVICT: begin
                n_out_item.action      = ACT_WB;
                n_out_item.target_page = rd_page;
                n_out_item.slot        = SLOT_W'(victim);
                n_out_item.last        = 1'b0;
            end
            EM_LOAD: begin
                n_out_item.action      = ACT_LOAD;
                n_out_item.target_page = r_req_page;
                n_out_item.slot        = SLOT_W'(victim);
            end
            EM_MARK: begin
                n_out_item.action      = ACT_MARKED;
                n_out_item.target_page = r_req_page;
                n_out_item.slot        = SLOT_W'(hit_idx);
            end
            EM_ABSENT: begin
                n_out_item.action      = ACT_ABSENT;
                n_out_item.target_page = r_req_page;
            end
            EM_FLUSH: begin
                n_out_item.action      = ACT_WB;
                n_out_item.target_page = rd_page;
                n_out_item.slot        = SLOT_W'(fl_idx);
            end
            default: begin
                n_out_item.action = ACT_NOFLUSH;
            end
        endcase
    end

    // Request capture and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_in_item.operation;
            r_req_page <= i_in_item.page;
        end
        if (i_cmd.scan) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_hit_vec[i] <= r_valid[i] && (r_page[i] == r_req_page);
            end
            r_cand_vec <= r_valid & r_dirty;
        end
    end

    // Page tags: no reset, only read behind a valid bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit == EM_LOAD) begin
            r_page[victim] <= r_req_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_head  <= '0;
            r_tail  <= IDX_W'(ENTRIES - 1);
        end else begin
            case (i_cmd.emit)
                EM_LOAD: begin
                    if (r_valid[victim]) begin
                        r_head <= head_next;
                    end
                    r_tail          <= victim;
                    r_valid[victim] <= 1'b1;
                    r_dirty[victim] <= 1'b0;
                end
                EM_EVICT: begin
                    r_dirty[victim] <= 1'b0;
                end
                EM_MARK: begin
                    r_dirty[hit_idx] <= 1'b1;
                end
                EM_FLUSH: begin
                    r_dirty[fl_idx] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EM_NONE) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A valid page lives in one slot only
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_hit_vec))
        else $error("page found in more than one slot");

    // Dirty marks only on valid slots
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty mark on an empty slot");

    // Ring pointers stay inside the slot range
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < IDX_W'(ENTRIES)) && (r_tail < IDX_W'(ENTRIES)))
        else $error("ring pointer out of range");

    // A result is only built when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != EM_NONE) |-> out_free)
        else $error("result overwrote a pending item");

    // A write-back on eviction is always followed by the load
    a_evict_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit == EM_EVICT) |=> !i_cmd.capture)
        else $error("new request taken between write-back and load");

endmodule

// ----- hw/rtl/fifo_page_buffer_cache_top.sv -----
// Page-buffer directory with 25 fully associative slots, FIFO replacement
// and write-back dirty marks. Send one request item per handshake: read
// (operation 0), mark modified (1) or flush one dirty page (2); code 3 is
// dropped with no result. A read hit or any mark/flush gives one result
// item; a read miss gives a load item, preceded by a write-back item (last
// low) when the evicted slot is dirty. The accepted request is captured,
// then its page is compared against all slot tags in parallel and the
// hit and dirty vectors are registered, then the request is resolved and
// the result is loaded into the output register; the load item follows
// an eviction write-back, and a stalled output side holds either back.
// The block takes no new request until the current one has loaded its
// last result, but a result waiting in the output register does not
// block acceptance of the next request. Reset is synchronous and leaves
// all slots empty; there is no clearing pass.
module fifo_page_buffer_cache_top
    import fpbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // request channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Controller/datapath handshake
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: capture, tag scan, resolve, optional second result
    fpbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tags, valid/dirty bits, ring pointers and the output register
    fpbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
